// File: rtl/rtd_pkg.sv
`default_nettype none

package rtd_pkg;

  localparam int RTD_ROM_ENTRIES = 4096;
  localparam int RTD_IDX_W       = $clog2(RTD_ROM_ENTRIES);
  localparam int RTD_Q_DEPTH     = 4;
  localparam int RTD_Q_AW        = $clog2(RTD_Q_DEPTH);
  localparam int RTD_Q_CW        = $clog2(RTD_Q_DEPTH + 1);
  localparam int RTD_FDIV_SHIFT  = 14;

  localparam logic [31:0] RTD_FILL_NUM     = 32'h7fff_ffff;
  localparam logic [31:0] RTD_SAT_POS      = 32'h7fff_ffff;
  localparam logic [31:0] RTD_SAT_NEG      = 32'h8000_0000;
  localparam logic [31:0] RTD_FRECIP_LIMIT = 32'd4;

  typedef enum logic [2:0] {
    KIND_UDIV   = 3'd0,
    KIND_SDIV   = 3'd1,
    KIND_URECIP = 3'd2,
    KIND_SRECIP = 3'd3,
    KIND_FDIV   = 3'd4,
    KIND_FRECIP = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    SH_0  = 3'd0,
    SH_4  = 3'd1,
    SH_8  = 3'd2,
    SH_12 = 3'd3,
    SH_16 = 3'd4,
    SH_20 = 3'd5
  } shift_t;

  // classified word as it waits in the queue
  typedef struct packed {
    kind_t                kind;
    logic [32:0]          mul_a;
    logic [RTD_IDX_W-1:0] idx;
    shift_t               sh;
    logic                 neg_r;
    logic                 neg_q;
    logic                 clamp;
    logic                 clamp_neg;
  } item_t;

  typedef struct packed {
    logic                 en;
    logic [RTD_IDX_W-1:0] addr;
    logic [31:0]          data;
  } ram_wr_t;

endpackage

`default_nettype wire

// File: rtl/rtd_ram.sv
`default_nettype none

module rtd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: rtl/rtd_fill.sv
`default_nettype none

module rtd_fill (
  input  logic            clk,
  input  logic            rst_n,
  output logic            busy,
  output rtd_pkg::ram_wr_t wr
);
  import rtd_pkg::*;

  localparam logic [RTD_IDX_W-1:0] LAST_IDX = RTD_IDX_W'(RTD_ROM_ENTRIES - 1);

  logic                 busy_r, busy_nxt;
  logic [RTD_IDX_W-1:0] idx_r, idx_nxt;
  logic [1:0]           step_r, step_nxt;
  logic [RTD_IDX_W-1:0] rem_r, rem_nxt;
  logic [31:0]          quo_r, quo_nxt;
  ram_wr_t              wr_nxt;

  // 8 quotient bits per cycle; each entry is written once its last numerator byte is done
  always_comb begin
    logic [7:0]         num_byte;
    logic [RTD_IDX_W:0] rem;
    logic [31:0]        quo;
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    wr_nxt   = '0;
    unique case (step_r)
      2'd0: num_byte = RTD_FILL_NUM[31:24];
      2'd1: num_byte = RTD_FILL_NUM[23:16];
      2'd2: num_byte = RTD_FILL_NUM[15:8];
      default: num_byte = RTD_FILL_NUM[7:0];
    endcase
    rem = {1'b0, rem_r};
    quo = quo_r;
    for (int j = 7; j >= 0; j--) begin
      rem = {rem[RTD_IDX_W-1:0], num_byte[j]};
      if (rem >= {1'b0, idx_r}) begin
        rem = rem - {1'b0, idx_r};
        quo = {quo[30:0], 1'b1};
      end else begin
        quo = {quo[30:0], 1'b0};
      end
    end
    if (busy_r) begin
      if (idx_r == '0) begin
        wr_nxt.en   = 1'b1;
        wr_nxt.addr = idx_r;
        wr_nxt.data = '0;
        idx_nxt     = idx_r + 1'b1;
      end else if (step_r == 2'd3) begin
        wr_nxt.en   = 1'b1;
        wr_nxt.addr = idx_r;
        wr_nxt.data = {quo[30:0], 1'b0};
        step_nxt    = '0;
        rem_nxt     = '0;
        quo_nxt     = '0;
        if (idx_r == LAST_IDX) begin
          busy_nxt = 1'b0;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end else begin
        step_nxt = step_r + 1'b1;
        rem_nxt  = rem[RTD_IDX_W-1:0];
        quo_nxt  = quo;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
      step_r <= '0;
      rem_r  <= '0;
      quo_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      step_r <= step_nxt;
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
    end
  end

  assign busy = busy_r;
  assign wr   = wr_nxt;

endmodule

`default_nettype wire

// File: rtl/rtd_front.sv
`default_nettype none

module rtd_front (
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [63:0]   in_tdata,
  input  logic [2:0]    in_tuser,
  input  logic          fill_busy,
  input  logic          q_full,
  output logic          push,
  output rtd_pkg::item_t item
);
  import rtd_pkg::*;

  logic [31:0] a, b;
  logic [31:0] abs_a, abs_b, rmag, shifted;
  logic        a_min, b_min, mag_b, fdiv_clamp, frecip_clamp;
  kind_t       kind;

  assign a     = in_tdata[31:0];
  assign b     = in_tdata[63:32];
  assign kind  = kind_t'(in_tuser);
  assign abs_a = a[31] ? 32'd0 - a : a;
  assign abs_b = b[31] ? 32'd0 - b : b;
  assign a_min = (a == RTD_SAT_NEG);
  assign b_min = (b == RTD_SAT_NEG);

  // most negative operands keep a negative absolute value, so the clamp tests treat them apart
  assign fdiv_clamp   = b_min
                     || (!a_min && ({14'd0, abs_a[31:RTD_FDIV_SHIFT]} >= abs_b));
  assign frecip_clamp = b_min || (abs_b <= RTD_FRECIP_LIMIT);

  always_comb begin
    item       = '0;
    item.kind  = kind;
    mag_b      = 1'b0;
    unique case (kind)
      KIND_UDIV: begin
        item.mul_a = {1'b0, a};
      end
      KIND_SDIV: begin
        mag_b      = 1'b1;
        item.mul_a = {1'b0, abs_a};
        item.neg_q = a[31] ^ b[31];
      end
      KIND_URECIP: begin
      end
      KIND_SRECIP: begin
        mag_b      = 1'b1;
        item.neg_r = b[31];
      end
      KIND_FDIV: begin
        mag_b          = 1'b1;
        item.mul_a     = {a[31], a};
        item.neg_r     = b[31];
        item.clamp     = fdiv_clamp;
        item.clamp_neg = a[31] ^ b[31];
      end
      KIND_FRECIP: begin
        mag_b          = 1'b1;
        item.neg_r     = b[31];
        item.clamp     = frecip_clamp;
        item.clamp_neg = b[31];
      end
      default: begin
      end
    endcase
    rmag = mag_b ? abs_b : b;
    priority if (rmag < 32'h0000_1000) begin
      item.sh = SH_0;
    end else if (rmag < 32'h0001_0000) begin
      item.sh = SH_4;
    end else if (rmag < 32'h0010_0000) begin
      item.sh = SH_8;
    end else if (rmag < 32'h0100_0000) begin
      item.sh = SH_12;
    end else if (rmag < 32'h1000_0000) begin
      item.sh = SH_16;
    end else begin
      item.sh = SH_20;
    end
    unique case (item.sh)
      SH_0:    shifted = rmag;
      SH_4:    shifted = rmag >> 4;
      SH_8:    shifted = rmag >> 8;
      SH_12:   shifted = rmag >> 12;
      SH_16:   shifted = rmag >> 16;
      default: shifted = rmag >> 20;
    endcase
    item.idx = shifted[RTD_IDX_W-1:0];
  end

  assign in_tready = !fill_busy && !q_full;
  assign push      = in_tvalid && in_tready;

endmodule

`default_nettype wire

// File: rtl/rtd_queue.sv
`default_nettype none

module rtd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rtd_pkg::item_t push_item,
  input  logic          pop,
  output rtd_pkg::item_t head,
  output logic          empty,
  output logic          full
);
  import rtd_pkg::*;

  item_t                mem_r [RTD_Q_DEPTH];
  logic [RTD_Q_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [RTD_Q_CW-1:0]  cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  assign head  = mem_r[rd_ptr_r];
  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == RTD_Q_CW'(RTD_Q_DEPTH));

endmodule

`default_nettype wire

// File: rtl/rtd_back.sv
`default_nettype none

module rtd_back (
  input  logic             clk,
  input  logic             rst_n,
  input  rtd_pkg::ram_wr_t rom_wr,
  input  rtd_pkg::item_t   head,
  input  logic             q_empty,
  output logic             pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [31:0]      out_tdata,
  output logic             out_tuser
);
  import rtd_pkg::*;

  logic        en;
  logic [31:0] rom_rdata;

  logic        s1_v_r, s2_v_r, s3_v_r, out_v_r;
  item_t       s1_item_r, s2_item_r, s3_item_r;
  logic [31:0] s2_ur_r, s2_r_r, s3_ur_r, s3_r_r;
  logic [63:0] s3_prod_r;
  logic [31:0] out_q_r;
  logic        out_sat_r;

  logic [31:0]        ur_nxt, r_nxt, q_nxt, prod_hi;
  logic [32:0]        op_b;
  logic signed [65:0] prod_full;
  logic               sat_nxt;

  assign en  = !out_v_r || out_tready;
  assign pop = en && !q_empty;

  rtd_ram #(
    .WIDTH (32),
    .DEPTH (RTD_ROM_ENTRIES)
  ) u_rom (
    .clk   (clk),
    .we    (rom_wr.en),
    .waddr (rom_wr.addr),
    .wdata (rom_wr.data),
    .re    (en),
    .raddr (head.idx),
    .rdata (rom_rdata)
  );

  // reciprocal scaling and sign
  always_comb begin
    unique case (s1_item_r.sh)
      SH_0:    ur_nxt = rom_rdata;
      SH_4:    ur_nxt = rom_rdata >> 4;
      SH_8:    ur_nxt = rom_rdata >> 8;
      SH_12:   ur_nxt = rom_rdata >> 12;
      SH_16:   ur_nxt = rom_rdata >> 16;
      default: ur_nxt = rom_rdata >> 20;
    endcase
    r_nxt = s1_item_r.neg_r ? 32'd0 - ur_nxt : ur_nxt;
  end

  assign op_b      = (s2_item_r.kind == KIND_FDIV) ? {s2_r_r[31], s2_r_r} : {1'b0, s2_ur_r};
  assign prod_full = $signed(s2_item_r.mul_a) * $signed(op_b);
  assign prod_hi   = s3_prod_r[63:32];

  always_comb begin
    q_nxt   = '0;
    sat_nxt = 1'b0;
    unique case (s3_item_r.kind)
      KIND_UDIV:   q_nxt = prod_hi;
      KIND_SDIV:   q_nxt = s3_item_r.neg_q ? 32'd0 - prod_hi : prod_hi;
      KIND_URECIP: q_nxt = s3_ur_r;
      KIND_SRECIP: q_nxt = s3_r_r;
      KIND_FDIV, KIND_FRECIP: begin
        if (s3_item_r.clamp) begin
          q_nxt   = s3_item_r.clamp_neg ? RTD_SAT_NEG : RTD_SAT_POS;
          sat_nxt = 1'b1;
        end else if (s3_item_r.kind == KIND_FDIV) begin
          q_nxt = s3_prod_r[47:16];
        end else begin
          q_nxt = s3_r_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r  <= pop;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      out_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_item_r <= head;
      s2_item_r <= s1_item_r;
      s2_ur_r   <= ur_nxt;
      s2_r_r    <= r_nxt;
      s3_item_r <= s2_item_r;
      s3_ur_r   <= s2_ur_r;
      s3_r_r    <= s2_r_r;
      s3_prod_r <= prod_full[63:0];
      out_q_r   <= q_nxt;
      out_sat_r <= sat_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_q_r;
  assign out_tuser  = out_sat_r;

endmodule

`default_nettype wire

// File: rtl/reciprocal_table_divider.sv
// channel   dir  tdata                               tuser
// in_       in   [31:0] dividend, [63:32] divisor    [2:0] kind
// out_      out  [31:0] quotient                     [0] saturated
//
// One word per cycle while in_tready is high.
// After reset the reciprocal ROM is built by a radix-256 divider, with
// in_tready low until the last entry is written.
// A 4-deep queue parts the front from the ROM/multiply pipeline, so inputs
// are taken while a result waits; the pipeline holds when out_tready is low.
`default_nettype none

module reciprocal_table_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // dividend, divisor
  input  logic [2:0]  in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // quotient
  output logic        out_tuser   // saturated
);
  import rtd_pkg::*;

  logic    fill_busy, q_full, q_empty, push, pop;
  ram_wr_t rom_wr;
  item_t   push_item, head;

  rtd_fill u_fill (
    .clk   (clk),
    .rst_n (rst_n),
    .busy  (fill_busy),
    .wr    (rom_wr)
  );

  rtd_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .fill_busy (fill_busy),
    .q_full    (q_full),
    .push      (push),
    .item      (push_item)
  );

  rtd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  rtd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .rom_wr     (rom_wr),
    .head       (head),
    .q_empty    (q_empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

// File: rtl/rtd_checker.sv
`default_nettype none

module rtd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser
);
  import rtd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word dropped or changed while stalled");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == RTD_SAT_POS || out_tdata == RTD_SAT_NEG)
    else $error("saturated flag without clamp value");

  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_rst_fill: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input taken before ROM fill");

endmodule

bind reciprocal_table_divider rtd_checker u_rtd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
